// ----- hdl/cwfp_pkg.sv -----
// Shared types, codes and helpers of the channel word formatter and packer.
package cwfp_pkg;

  // Channel status codes.
  localparam logic [1:0] ST_ZERO_SUPP = 2'd0;
  localparam logic [1:0] ST_TOA_SUPP  = 2'd1;
  localparam logic [1:0] ST_INVALID   = 2'd2;
  localparam logic [1:0] ST_AUTO_FULL = 2'd3;

  // Configuration register indexes.
  localparam logic REG_CHARACTERIZE = 1'b0;
  localparam logic REG_PASS_THROUGH = 1'b1;

  typedef enum logic [1:0] {
    LEN16 = 2'd0,
    LEN24 = 2'd1,
    LEN32 = 2'd2
  } len_t;

  typedef struct packed {
    logic characterize;
    logic pass_through;
  } cfg_t;

  // One classified channel as it travels from the front to the back.
  typedef struct packed {
    logic        has_word;  // a code word is to be packed
    len_t        len;
    logic [31:0] word_al;   // code word, left aligned
    logic        last;
    logic        err;       // sticky error flag after this channel
  } entry_t;

  function automatic logic [5:0] len_bits(input len_t len);
    case (len)
      LEN16:   len_bits = 6'd16;
      LEN24:   len_bits = 6'd24;
      LEN32:   len_bits = 6'd32;
      default: len_bits = 6'd32;
    endcase
  endfunction

endpackage

// ----- hdl/cwfp_if.sv -----
// Channel and packed-word stream interfaces.
interface chan_if;
  logic       valid;
  logic       ready;
  logic       channel_enabled;
  logic [1:0] status_code;
  logic [9:0] adc_value;
  logic [9:0] adc_prev;
  logic [9:0] tot_value;
  logic [9:0] toa_value;
  logic       frame_passes_zs;
  logic       frame_passes_zs_prev;
  logic       toa_forced;
  logic       last_channel;

  modport source (
    output valid, channel_enabled, status_code, adc_value, adc_prev, tot_value,
           toa_value, frame_passes_zs, frame_passes_zs_prev, toa_forced, last_channel,
    input  ready
  );
  modport sink (
    input  valid, channel_enabled, status_code, adc_value, adc_prev, tot_value,
           toa_value, frame_passes_zs, frame_passes_zs_prev, toa_forced, last_channel,
    output ready
  );
endinterface

interface word_if;
  logic        valid;
  logic        ready;
  logic [31:0] packed_word;
  logic        last_word;
  logic        zs_error;

  modport source (output valid, packed_word, last_word, zs_error, input ready);
  modport sink (input valid, packed_word, last_word, zs_error, output ready);
endinterface

// ----- hdl/cwfp_front.sv -----
// Front end: accepts channels, builds the code word and tracks the error flag.
module cwfp_front
  import cwfp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  chan_if.sink   chan,
  input  logic   q_full,
  output logic   push,
  output entry_t entry
);

  logic        err_sticky;
  logic        err_sticky_next;
  logic        drop;
  logic [31:0] word_al;
  len_t        len;

  assign chan.ready = !q_full;
  assign push       = chan.valid && chan.ready;

  always_comb begin
    drop    = 1'b0;
    len     = LEN32;
    word_al = '0;
    if (cfg.characterize) begin
      word_al = {chan.status_code, chan.adc_value, chan.tot_value, chan.toa_value};
    end else if (cfg.pass_through) begin
      word_al = {chan.status_code, chan.adc_prev,
                 (chan.status_code[1] ? chan.tot_value : chan.adc_value), chan.toa_value};
    end else begin
      case (chan.status_code)
        ST_ZERO_SUPP: begin
          if (!chan.frame_passes_zs) begin
            drop = 1'b1;
          end else if (chan.frame_passes_zs_prev) begin
            if (chan.toa_value != 10'd0 || chan.toa_forced) begin
              word_al = {2'b01, chan.adc_prev, chan.adc_value, chan.toa_value};
            end else begin
              len     = LEN24;
              word_al = {4'b0000, chan.adc_prev, chan.adc_value, 8'h00};
            end
          end else if (chan.toa_forced) begin
            len     = LEN24;
            word_al = {4'b0011, chan.adc_value, chan.toa_value, 8'h00};
          end else begin
            len     = LEN16;
            word_al = {4'b0001, chan.adc_value, 2'b00, 16'h0000};
          end
        end
        ST_TOA_SUPP: begin
          len     = LEN24;
          word_al = {4'b0010, chan.adc_prev, chan.adc_value, 8'h00};
        end
        ST_INVALID: begin
          word_al = {2'b10, chan.adc_prev, chan.adc_value, chan.toa_value};
        end
        ST_AUTO_FULL: begin
          word_al = {2'b11, chan.adc_prev, chan.tot_value, chan.toa_value};
        end
        default: begin
          word_al = '0;
        end
      endcase
    end
  end

  assign err_sticky_next = err_sticky || (push && chan.channel_enabled && drop);

  always_ff @(posedge clk) begin
    if (rst) begin
      err_sticky <= 1'b0;
    end else begin
      err_sticky <= err_sticky_next;
    end
  end

  assign entry.has_word = chan.channel_enabled && !drop;
  assign entry.len      = len;
  assign entry.word_al  = word_al;
  assign entry.last     = chan.last_channel;
  assign entry.err      = err_sticky_next;

endmodule

// ----- hdl/cwfp_queue.sv -----
// Two-entry queue between the front end and the packer.
module cwfp_queue
  import cwfp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wr_entry,
  output logic   full,
  output logic   q_valid,
  output entry_t head,
  input  logic   pop
);

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> count != 2'd0)
    else $error("pop from empty queue");
  a_push_not_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");

endmodule

// ----- hdl/cwfp_back.sv -----
// Back end: merges code words into the accumulator and drives the output register.
module cwfp_back
  import cwfp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   q_valid,
  input  entry_t e,
  output logic   pop,
  word_if.source words
);

  logic [31:0] acc;
  logic [4:0]  fill;
  logic        word_full;
  logic        step;

  logic        out_valid;
  logic [31:0] out_word;
  logic        out_last;
  logic        out_err;

  logic [31:0] base_acc;
  logic [4:0]  base_fill;
  logic [63:0] window;
  logic [31:0] upper;
  logic [31:0] lower;
  logic [5:0]  sum;
  logic        split;
  logic        flush_full;
  logic        send_last;
  logic [31:0] acc_after;
  logic [1:0]  n_res;
  logic [31:0] r0;
  logic        r0_last;
  logic [31:0] cur_word;
  logic        cur_last;
  logic        done;
  logic        load_ok;
  logic        emit;

  always_comb begin
    base_acc   = word_full ? 32'd0 : acc;
    base_fill  = word_full ? 5'd0 : fill;
    window     = {e.word_al, 32'd0} >> base_fill;
    upper      = base_acc | window[63:32];
    lower      = window[31:0];
    sum        = {1'b0, base_fill} + len_bits(e.len);
    split      = e.has_word && (sum > 6'd32);
    flush_full = e.has_word && word_full;
    send_last  = e.last;
    if (split) begin
      acc_after = lower;
    end else if (e.has_word) begin
      acc_after = upper;
    end else begin
      acc_after = acc;
    end
    n_res = {1'b0, flush_full} + {1'b0, split} + {1'b0, send_last};
    // A held full word and a split never occur together, so a second result is the flush.
    if (flush_full) begin
      r0      = acc;
      r0_last = 1'b0;
    end else if (split) begin
      r0      = upper;
      r0_last = 1'b0;
    end else begin
      r0      = acc_after;
      r0_last = 1'b1;
    end
    cur_word = step ? acc_after : r0;
    cur_last = step ? 1'b1 : r0_last;
    done     = (n_res == 2'd2) ? step : 1'b1;
    load_ok  = !out_valid || words.ready;
    emit     = q_valid && (n_res != 2'd0) && load_ok;
    pop      = q_valid && ((n_res == 2'd0) || (load_ok && done));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      fill      <= '0;
      word_full <= 1'b0;
      step      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        step      <= !done;
        out_valid <= 1'b1;
      end else if (words.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (e.last) begin
          acc       <= '0;
          fill      <= '0;
          word_full <= 1'b0;
        end else if (e.has_word) begin
          acc       <= acc_after;
          fill      <= sum[4:0];
          word_full <= (sum == 6'd32);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word <= cur_word;
      out_last <= cur_last;
      out_err  <= e.err;
    end
  end

  assign words.valid       = out_valid;
  assign words.packed_word = out_word;
  assign words.last_word   = out_last;
  assign words.zs_error    = out_err;

  a_step_has_item: assert property (@(posedge clk) disable iff (rst) step |-> q_valid)
    else $error("second result pending without a queued item");
  a_full_fill_zero: assert property (@(posedge clk) disable iff (rst) word_full |-> fill == 5'd0)
    else $error("held full word with nonzero fill");
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
      (pop && e.last) |=> (fill == 5'd0 && !word_full && acc == 32'd0))
    else $error("accumulator not cleared after group end");

endmodule

// ----- hdl/channel_word_format_and_bit_packer.sv -----
// Top level of the channel word formatter and 32-bit MSB-first bit packer.
// One channel is accepted per clock while the queue is not full. A front end formats
// each enabled channel into a 16-, 24- or 32-bit code word and sets the sticky
// zero-suppression error flag; a two-entry queue carries classified channels to the
// packer, which merges them into a 32-bit accumulator and presents packed words through
// a single output register. A channel that yields two words (a held full word or a split
// word, followed by the end-of-group flush) leaves the queue only once both are loaded
// into the output register. Configuration is written through cfg_we, cfg_index and
// cfg_data; the user must do this only while idle, as the block does not enforce it.
module channel_word_format_and_bit_packer
  import cwfp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   cfg_we,
  input  logic   cfg_index,
  input  logic   cfg_data,
  chan_if.sink   chan,
  word_if.source words
);

  cfg_t   cfg;
  logic   push;
  logic   q_full;
  logic   q_valid;
  logic   pop;
  entry_t wr_entry;
  entry_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHARACTERIZE: cfg.characterize <= cfg_data;
        REG_PASS_THROUGH: cfg.pass_through <= cfg_data;
        default:          cfg              <= cfg;
      endcase
    end
  end

  cwfp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .chan   (chan),
    .q_full (q_full),
    .push   (push),
    .entry  (wr_entry)
  );

  cwfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .full     (q_full),
    .q_valid  (q_valid),
    .head     (head),
    .pop      (pop)
  );

  cwfp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .e       (head),
    .pop     (pop),
    .words   (words)
  );

endmodule
